// File: rtl/drt_pkg.sv
// ---------------------------------------------------------------------------
// Dirty rectangle tracker package
// Shared constants, register indexes, opcodes and the control bundle that
// passes from the top level to the box update logic.
// ---------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

    // Parameter defaults
    localparam int DEF_MAX_DIMENSION = 4096;
    localparam int DEF_COORD_BITS    = 16;

    // Configuration port shape
    localparam int CFG_BITS      = 13;
    localparam int CFG_ADDR_BITS = 1;

    // Page size after reset
    localparam logic [CFG_BITS-1:0] PAGE_WIDTH_RST  = 13'd320;
    localparam logic [CFG_BITS-1:0] PAGE_HEIGHT_RST = 13'd200;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PAGE_WIDTH  = 1'b0,
        REG_PAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Item opcodes, carried on the slave tuser
    typedef enum logic {
        OP_MARK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    // Control from the top level to the box update logic
    typedef struct packed {
        logic    advance;  // item moves from input register to result register
        t_opcode op;
    } t_box_ctl;

endpackage

`default_nettype wire

// File: rtl/drt_cfg.sv
// ---------------------------------------------------------------------------
// Dirty rectangle tracker page configuration
// Holds the page size registers and keeps them as the largest legal
// coordinate on each axis, so the datapath clamps with a single compare.
// ---------------------------------------------------------------------------
`default_nettype none

module drt_cfg #(
    parameter int MAX_DIMENSION = drt_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [drt_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  wire logic [drt_pkg::CFG_BITS-1:0]         i_cfg_data,
    output logic      [$clog2(MAX_DIMENSION)-1:0]     o_x_lim,
    output logic      [$clog2(MAX_DIMENSION)-1:0]     o_y_lim
);

    localparam int LIM_BITS = $clog2(MAX_DIMENSION);

    logic [LIM_BITS-1:0] r_x_lim;
    logic [LIM_BITS-1:0] r_y_lim;

    // Map a page size to its last pixel index: zero acts as one, oversize
    // saturates at the maximum dimension
    function automatic logic [LIM_BITS-1:0] size_limit(input logic [drt_pkg::CFG_BITS-1:0] s);
        if (s == '0) begin
            return '0;
        end
        if (32'(s) > 32'(MAX_DIMENSION)) begin
            return LIM_BITS'(MAX_DIMENSION - 1);
        end
        return LIM_BITS'(s - 1'b1);
    endfunction

    // Write the addressed page size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lim <= size_limit(drt_pkg::PAGE_WIDTH_RST);
            r_y_lim <= size_limit(drt_pkg::PAGE_HEIGHT_RST);
        end else if (i_cfg_we) begin
            unique case (drt_pkg::t_cfg_reg'(i_cfg_addr))
                drt_pkg::REG_PAGE_WIDTH: begin
                    r_x_lim <= size_limit(i_cfg_data);
                end
                drt_pkg::REG_PAGE_HEIGHT: begin
                    r_y_lim <= size_limit(i_cfg_data);
                end
            endcase
        end
    end

    assign o_x_lim = r_x_lim;
    assign o_y_lim = r_y_lim;

endmodule

`default_nettype wire

// File: rtl/drt_box.sv
// ---------------------------------------------------------------------------
// Dirty rectangle tracker box update
// Sorts and clamps the corners of one item, merges them into the stored box
// (or empties it on a clear) and presents the box as it stands before and after the item.
// ---------------------------------------------------------------------------
`default_nettype none

module drt_box #(
    parameter int MAX_DIMENSION = drt_pkg::DEF_MAX_DIMENSION,
    parameter int COORD_BITS    = drt_pkg::DEF_COORD_BITS
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire drt_pkg::t_box_ctl                         i_ctl,
    input  wire logic signed [COORD_BITS-1:0]              i_ax,
    input  wire logic signed [COORD_BITS-1:0]              i_ay,
    input  wire logic signed [COORD_BITS-1:0]              i_bx,
    input  wire logic signed [COORD_BITS-1:0]              i_by,
    input  wire logic        [$clog2(MAX_DIMENSION)-1:0]   i_x_lim,
    input  wire logic        [$clog2(MAX_DIMENSION)-1:0]   i_y_lim,
    // left, top, right, bottom from the lowest bit up
    output logic        [4*($clog2(MAX_DIMENSION)+1)-1:0]  o_next_box,
    output logic        [4*($clog2(MAX_DIMENSION)+1)-1:0]  o_cur_box,
    output logic                                           o_ignored
);

    localparam int LIM_BITS = $clog2(MAX_DIMENSION);
    localparam int BOX_BITS = LIM_BITS + 1;
    localparam int CMP_BITS = ((COORD_BITS > LIM_BITS) ? COORD_BITS : LIM_BITS) + 1;

    // Stored box; the edges mean nothing while the box is empty
    logic                r_empty;
    logic [LIM_BITS-1:0] r_left;
    logic [LIM_BITS-1:0] r_top;
    logic [LIM_BITS-1:0] r_right;
    logic [LIM_BITS-1:0] r_bottom;

    logic                n_empty;
    logic [LIM_BITS-1:0] n_left;
    logic [LIM_BITS-1:0] n_top;
    logic [LIM_BITS-1:0] n_right;
    logic [LIM_BITS-1:0] n_bottom;
    logic                n_ignored;

    logic signed [COORD_BITS-1:0] w_lx;
    logic signed [COORD_BITS-1:0] w_hx;
    logic signed [COORD_BITS-1:0] w_ly;
    logic signed [COORD_BITS-1:0] w_hy;
    logic        [LIM_BITS-1:0]   w_x1;
    logic        [LIM_BITS-1:0]   w_y1;
    logic        [LIM_BITS-1:0]   w_x2;
    logic        [LIM_BITS-1:0]   w_y2;

    // Clamp a signed coordinate into 0 .. lim
    function automatic logic [LIM_BITS-1:0] clamp(
        input logic signed [COORD_BITS-1:0] v,
        input logic        [LIM_BITS-1:0]   lim
    );
        logic signed [CMP_BITS-1:0] v_ext;
        logic signed [CMP_BITS-1:0] lim_ext;
        v_ext   = {{(CMP_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
        lim_ext = {{(CMP_BITS - LIM_BITS){1'b0}}, lim};
        if (v[COORD_BITS-1]) begin
            return '0;
        end
        if (v_ext > lim_ext) begin
            return lim;
        end
        return v_ext[LIM_BITS-1:0];
    endfunction

    // Present an edge, all ones when the box is empty
    function automatic logic [BOX_BITS-1:0] show_edge(
        input logic                empty,
        input logic [LIM_BITS-1:0] val
    );
        return empty ? '1 : {1'b0, val};
    endfunction

    // Sort the corners into upper left and lower right
    assign w_lx = (i_ax < i_bx) ? i_ax : i_bx;
    assign w_hx = (i_ax < i_bx) ? i_bx : i_ax;
    assign w_ly = (i_ay < i_by) ? i_ay : i_by;
    assign w_hy = (i_ay < i_by) ? i_by : i_ay;

    // Clamp to the page
    assign w_x1 = clamp(w_lx, i_x_lim);
    assign w_x2 = clamp(w_hx, i_x_lim);
    assign w_y1 = clamp(w_ly, i_y_lim);
    assign w_y2 = clamp(w_hy, i_y_lim);

    // Merge the item into the box
    always_comb begin
        n_empty   = r_empty;
        n_left    = r_left;
        n_top     = r_top;
        n_right   = r_right;
        n_bottom  = r_bottom;
        n_ignored = 1'b0;
        priority if (i_ctl.op == drt_pkg::OP_CLEAR) begin
            n_empty = 1'b1;
        end else if (w_hx[COORD_BITS-1] || w_hy[COORD_BITS-1]) begin
            // both x or both y off the page on the negative side
            n_ignored = 1'b1;
        end else begin
            n_empty  = 1'b0;
            n_left   = (r_empty || (r_left > w_x1))   ? w_x1 : r_left;
            n_top    = (r_empty || (r_top > w_y1))    ? w_y1 : r_top;
            n_right  = (r_empty || (r_right < w_x2))  ? w_x2 : r_right;
            n_bottom = (r_empty || (r_bottom < w_y2)) ? w_y2 : r_bottom;
        end
    end

    // Hold the empty flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= 1'b1;
        end else if (i_ctl.advance) begin
            r_empty <= n_empty;
        end
    end

    // Advance the edges with each item
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
        end
    end

    assign o_next_box = {show_edge(n_empty, n_bottom), show_edge(n_empty, n_right),
                         show_edge(n_empty, n_top),    show_edge(n_empty, n_left)};
    assign o_cur_box  = {show_edge(r_empty, r_bottom), show_edge(r_empty, r_right),
                         show_edge(r_empty, r_top),    show_edge(r_empty, r_left)};
    assign o_ignored  = n_ignored;

endmodule

`default_nettype wire

// File: rtl/dirty_rectangle_tracker.sv
// Path: an item passes from the input register to the result register, which
//   offers it on the master stream; the box update is one pass of compare and
//   select logic between the input and result registers.
// Throughput: one item per cycle; the input and result registers each take a
//   new transfer whenever the stage after them can move.
// Reset: synchronous, active low; empties the box, sets the page to 320 x 200.
// ---------------------------------------------------------------------------
// Dirty rectangle tracker
// Keeps the bounding box of all rectangles marked dirty since the last clear
// and returns the box after every item.
// ---------------------------------------------------------------------------
`default_nettype none

module dirty_rectangle_tracker #(
    parameter int MAX_DIMENSION = drt_pkg::DEF_MAX_DIMENSION,
    parameter int COORD_BITS    = drt_pkg::DEF_COORD_BITS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    // slave stream
    input  wire logic                                          i_s_tvalid,
    output logic                                               o_s_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y from the lowest bit up
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]             i_s_tdata,
    // opcode
    input  wire logic                                          i_s_tuser,
    // master stream
    output logic                                               o_m_tvalid,
    input  wire logic                                          i_m_tready,
    // box_left, box_top, box_right, box_bottom from the lowest bit up
    output logic [((4*($clog2(MAX_DIMENSION)+1)+7)/8)*8-1:0]   o_m_tdata,
    // ignored
    output logic                                               o_m_tuser,
    // configuration writes
    input  wire logic                                          i_cfg_we,
    input  wire logic [drt_pkg::CFG_ADDR_BITS-1:0]             i_cfg_addr,
    input  wire logic [drt_pkg::CFG_BITS-1:0]                  i_cfg_data
);

    localparam int LIM_BITS      = $clog2(MAX_DIMENSION);
    localparam int BOX_BITS      = LIM_BITS + 1;
    localparam int OUT_DATA_BITS = ((4*BOX_BITS + 7) / 8) * 8;

    // Input register
    logic                      r_in_valid;
    drt_pkg::t_opcode          r_in_op;
    logic [4*COORD_BITS-1:0]   r_in_coords;

    // Result register
    logic                      r_out_valid;
    logic [4*BOX_BITS-1:0]     r_out_box;
    logic                      r_out_ignored;

    logic                      w_out_ready;
    logic                      w_adv;
    drt_pkg::t_box_ctl         w_ctl;
    logic [LIM_BITS-1:0]       w_x_lim;
    logic [LIM_BITS-1:0]       w_y_lim;
    logic [4*BOX_BITS-1:0]     w_next_box;
    logic [4*BOX_BITS-1:0]     w_cur_box;
    logic                      w_ignored;

    // Handshake: each register takes a transfer when the one after it can move
    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_adv       = r_in_valid && w_out_ready;
    assign o_s_tready  = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Capture the item on a transfer
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op     <= drt_pkg::t_opcode'(i_s_tuser);
            r_in_coords <= i_s_tdata[4*COORD_BITS-1:0];
        end
    end

    assign w_ctl.advance = w_adv;
    assign w_ctl.op      = r_in_op;

    drt_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_x_lim    (w_x_lim),
        .o_y_lim    (w_y_lim)
    );

    drt_box #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .COORD_BITS    (COORD_BITS)
    ) u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_ax       (r_in_coords[0*COORD_BITS +: COORD_BITS]),
        .i_ay       (r_in_coords[1*COORD_BITS +: COORD_BITS]),
        .i_bx       (r_in_coords[2*COORD_BITS +: COORD_BITS]),
        .i_by       (r_in_coords[3*COORD_BITS +: COORD_BITS]),
        .i_x_lim    (w_x_lim),
        .i_y_lim    (w_y_lim),
        .o_next_box (w_next_box),
        .o_cur_box  (w_cur_box),
        .o_ignored  (w_ignored)
    );

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Load the result as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_box     <= w_next_box;
            r_out_ignored <= w_ignored;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'(r_out_box);
    assign o_m_tuser  = r_out_ignored;

    // A clear leaves an empty box and is never flagged as ignored
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_op == drt_pkg::OP_CLEAR))
        |=> (o_m_tvalid && (r_out_box == '1) && !o_m_tuser))
        else $error("clear did not empty the box");

    // A filled box keeps its edges in order
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_out_box[BOX_BITS-1])
        |-> ((r_out_box[0*BOX_BITS +: BOX_BITS] <= r_out_box[2*BOX_BITS +: BOX_BITS])
          && (r_out_box[1*BOX_BITS +: BOX_BITS] <= r_out_box[3*BOX_BITS +: BOX_BITS])))
        else $error("box edges out of order");

    // A rejected mark leaves the stored box untouched
    a_ignore_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_ignored) |=> (w_cur_box == $past(w_cur_box)))
        else $error("ignored mark changed the box");

endmodule

`default_nettype wire

// File: test/dirty_rectangle_tracker_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Dirty rectangle tracker testbench
// Drives mark and clear items on the input stream and checks every box on the
// output stream against a cycle-free tracker kept alongside, or against the box
// that a typed table row carries. A table of directed items opens the run.
// Random phases follow under several page sizes and with stalls on both streams.
// ---------------------------------------------------------------------------

module dirty_rectangle_tracker_tb;

    localparam int MAX_DIM      = drt_pkg::DEF_MAX_DIMENSION;
    localparam int CRD_W        = drt_pkg::DEF_COORD_BITS;
    localparam int CFG_W        = drt_pkg::CFG_BITS;
    localparam int BOX_W        = $clog2(MAX_DIM) + 1;
    localparam int IN_DATA_W    = ((4 * CRD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((4 * BOX_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRESS_CYCLES = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 280;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_ROWS     = 17;

    typedef logic signed [CRD_W-1:0] t_coord;
    typedef logic signed [BOX_W-1:0] t_edge;

    typedef struct packed {
        t_edge left;
        t_edge top;
        t_edge right;
        t_edge bottom;
        logic  ign;
    } t_box_res;

    typedef struct packed {
        drt_pkg::t_opcode op;
        t_coord           ax;
        t_coord           ay;
        t_coord           bx;
        t_coord           by;
        logic             typed;
        t_box_res         want;
    } t_dir_row;

    localparam t_box_res EMPTY_BOX  = '{-13'sd1, -13'sd1, -13'sd1, -13'sd1, 1'b0};
    localparam t_box_res SKIP_EMPTY = '{-13'sd1, -13'sd1, -13'sd1, -13'sd1, 1'b1};
    localparam t_box_res NO_WANT    = '0;

    // Directed items; a row with typed set carries its own expected box
    localparam t_dir_row DIR_ROWS [NUM_ROWS] = '{
        '{drt_pkg::OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, EMPTY_BOX},
        '{drt_pkg::OP_MARK, 16'sd10, 16'sd20, 16'sd5, 16'sd7, 1'b1,
          '{13'sd5, 13'sd7, 13'sd10, 13'sd20, 1'b0}},
        '{drt_pkg::OP_MARK, -16'sd5, 16'sd300, 16'sd400, -16'sd3, 1'b1,
          '{13'sd0, 13'sd0, 13'sd319, 13'sd199, 1'b0}},
        '{drt_pkg::OP_CLEAR, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, EMPTY_BOX},
        '{drt_pkg::OP_MARK, -16'sd1, 16'sd5, -16'sd100, 16'sd50, 1'b1, SKIP_EMPTY},
        '{drt_pkg::OP_MARK, 16'sd5, -16'sd1, 16'sd6, 16'sh8000, 1'b1, SKIP_EMPTY},
        '{drt_pkg::OP_MARK, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1,
          '{13'sd0, 13'sd0, 13'sd319, 13'sd199, 1'b0}},
        '{drt_pkg::OP_CLEAR, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, EMPTY_BOX},
        '{drt_pkg::OP_MARK, 16'sd100, 16'sd50, 16'sd100, 16'sd50, 1'b1,
          '{13'sd100, 13'sd50, 13'sd100, 13'sd50, 1'b0}},
        '{drt_pkg::OP_MARK, 16'sd30, 16'sd60, 16'sd40, 16'sd70, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, 16'sd200, 16'sd10, 16'sd150, 16'sd20, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, -16'sd5, 16'sd3, 16'sd0, 16'sd4, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, -16'sd3, 16'sd10, -16'sd4, 16'sd20, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, 16'sh5555, 16'sh2AAA, 16'shAAAA, 16'shD555, 1'b0, NO_WANT},
        '{drt_pkg::OP_MARK, 16'sd319, 16'sd199, 16'sd320, 16'sd200, 1'b0, NO_WANT},
        '{drt_pkg::OP_CLEAR, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b1, EMPTY_BOX}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [drt_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // Tracker state kept by the testbench
    logic [CFG_W-1:0] page_w = drt_pkg::PAGE_WIDTH_RST;
    logic [CFG_W-1:0] page_h = drt_pkg::PAGE_HEIGHT_RST;
    int box_l = -1;
    int box_t = -1;
    int box_r = -1;
    int box_b = -1;

    t_box_res box_q[$];

    int          src_idle_pct = 15;
    int          snk_idle_pct = 74;
    logic        press_req = 1'b0;
    int unsigned held_cycles = 0;
    int unsigned quiet_cycles = 0;
    int          errors = 0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_clears = 0;
    int          n_rejected = 0;

    dirty_rectangle_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        // corner_a_x, corner_a_y, corner_b_x, corner_b_y from the lowest bit up
        .i_s_tdata  (i_s_tdata),
        // opcode
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        // box_left, box_top, box_right, box_bottom from the lowest bit up
        .o_m_tdata  (o_m_tdata),
        // ignored
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Map a register value to the page size that clamping uses
    function automatic int eff_size(logic [CFG_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_DIM) return MAX_DIM;
        return int'(s);
    endfunction

    function automatic int clamp_to(int v, int size);
        if (v < 0) return 0;
        if (v >= size) return size - 1;
        return v;
    endfunction

    // Update the tracked box with one item and return the box after it
    function automatic t_box_res track_item(drt_pkg::t_opcode op, t_coord ax, t_coord ay,
                                            t_coord bx, t_coord by);
        t_box_res res;
        int lx, hx, ly, hy, w, h, x1, y1, x2, y2;
        res.ign = 1'b0;
        if (op == drt_pkg::OP_CLEAR) begin
            box_l = -1;
            box_t = -1;
            box_r = -1;
            box_b = -1;
        end else begin
            lx = (ax < bx) ? ax : bx;
            hx = (ax < bx) ? bx : ax;
            ly = (ay < by) ? ay : by;
            hy = (ay < by) ? by : ay;
            if (hx < 0 || hy < 0) begin
                res.ign = 1'b1;
            end else begin
                w  = eff_size(page_w);
                h  = eff_size(page_h);
                x1 = clamp_to(lx, w);
                y1 = clamp_to(ly, h);
                x2 = clamp_to(hx, w);
                y2 = clamp_to(hy, h);
                // an empty edge takes the new value outright
                if (box_l < 0 || box_l > x1) box_l = x1;
                if (box_t < 0 || box_t > y1) box_t = y1;
                if (box_r < 0 || box_r < x2) box_r = x2;
                if (box_b < 0 || box_b < y2) box_b = y2;
            end
        end
        res.left   = box_l[BOX_W-1:0];
        res.top    = box_t[BOX_W-1:0];
        res.right  = box_r[BOX_W-1:0];
        res.bottom = box_b[BOX_W-1:0];
        return res;
    endfunction

    // Pick a coordinate: mostly on the page, some just off it, some anywhere
    function automatic t_coord rand_coord(int span);
        case ($urandom_range(7))
            0: return t_coord'($urandom_range(16'hFFFF));
            1: return t_coord'(-int'($urandom_range(1, 40)));
            2: return t_coord'(span - 2 + int'($urandom_range(0, 3)));
            default: return t_coord'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic void check_field(string name, int want, int seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            errors++;
        end
    endfunction

    // Offer one item, hold it until the transfer, then record the expected box
    task automatic offer_item(drt_pkg::t_opcode op, t_coord ax, t_coord ay, t_coord bx,
                              t_coord by, logic typed, t_box_res want);
        t_box_res pred;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {by, bx, ay, ax};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = track_item(op, ax, ay, bx, by);
        box_q.push_back(typed ? want : pred);
        n_items++;
        if (op == drt_pkg::OP_CLEAR) n_clears++;
        if (pred.ign) n_rejected++;
    endtask

    // Write one page register once the block has drained
    task automatic write_page(drt_pkg::t_cfg_reg idx, logic [CFG_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == drt_pkg::REG_PAGE_WIDTH) page_w = val;
        else page_h = val;
    endtask

    // Receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (press_req && held_cycles < PRESS_CYCLES) begin
            i_m_tready  <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expected box
    always @(posedge i_clk) begin
        t_box_res want;
        t_box_res seen;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.left   = o_m_tdata[BOX_W-1:0];
            seen.top    = o_m_tdata[2*BOX_W-1:BOX_W];
            seen.right  = o_m_tdata[3*BOX_W-1:2*BOX_W];
            seen.bottom = o_m_tdata[4*BOX_W-1:3*BOX_W];
            seen.ign    = o_m_tuser;
            if (box_q.size() == 0) begin
                $display("%0t: result with no item pending, actual %p", $time, seen);
                errors++;
            end else begin
                want = box_q.pop_front();
                check_field("box_left", want.left, seen.left);
                check_field("box_top", want.top, seen.top);
                check_field("box_right", want.right, seen.right);
                check_field("box_bottom", want.bottom, seen.bottom);
                check_field("ignored", int'(want.ign), int'(seen.ign));
                n_checked++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("dirty_rectangle_tracker_tb failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] widths  [NUM_PHASES];
        logic [CFG_W-1:0] heights [NUM_PHASES];
        int     mode;
        int     span_x, span_y;
        t_coord ax, ay, bx, by;
        drt_pkg::t_opcode op;

        widths  = '{13'd320, 13'd0, 13'd4096, 13'd1, 13'd4097, 13'd0};
        heights = '{13'd200, 13'd0, 13'd1, 13'd8191, 13'd4095, 13'd0};
        widths[NUM_PHASES-1]  = CFG_W'($urandom_range(2, MAX_DIM));
        heights[NUM_PHASES-1] = CFG_W'($urandom_range(2, MAX_DIM));

        // Hold reset, then release on a clock edge
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset page size
        for (int r = 0; r < NUM_ROWS; r++) begin
            offer_item(DIR_ROWS[r].op, DIR_ROWS[r].ax, DIR_ROWS[r].ay,
                       DIR_ROWS[r].bx, DIR_ROWS[r].by, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_page(drt_pkg::REG_PAGE_WIDTH, widths[p]);
            write_page(drt_pkg::REG_PAGE_HEIGHT, heights[p]);

            // Sender-light, then receiver-light, then no idling at all
            mode = p / 2;
            src_idle_pct  = (mode == 0) ? 15 : (mode == 1) ? 74 : 0;
            snk_idle_pct <= (mode == 0) ? 74 : (mode == 1) ? 15 : 0;
            if (p == 0) press_req <= 1'b1;

            span_x = eff_size(page_w);
            span_y = eff_size(page_h);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(99) < 6) ? drt_pkg::OP_CLEAR : drt_pkg::OP_MARK;
                ax = rand_coord(span_x);
                ay = rand_coord(span_y);
                // keep half the rectangles small around the first corner
                if ($urandom_range(1)) begin
                    bx = t_coord'(ax + int'($urandom_range(0, 16)) - 8);
                    by = t_coord'(ay + int'($urandom_range(0, 16)) - 8);
                end else begin
                    bx = rand_coord(span_x);
                    by = rand_coord(span_y);
                end
                offer_item(op, ax, ay, bx, by, 1'b0, NO_WANT);
            end
        end

        // Drain and let any stray result show up
        i_s_tvalid <= 1'b0;
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items (%0d from the table) over %0d page sizes;", n_items,
                 NUM_ROWS, NUM_PHASES + 1);
        $display("checked %0d boxes, %0d clears, %0d wholly negative marks, %0d errors",
                 n_checked, n_clears, n_rejected, errors);
        if (errors == 0)
            $display("dirty_rectangle_tracker_tb passed");
        else
            $display("dirty_rectangle_tracker_tb failed");
        $finish;
    end

endmodule
